// ----- sv/sorted_char_table_binary_search_core_macros.svh -----
// Assertion macros for the sorted character table search core.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef SORTED_CHAR_TABLE_BINARY_SEARCH_CORE_MACROS_SVH
`define SORTED_CHAR_TABLE_BINARY_SEARCH_CORE_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define SCBS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define SCBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/scbs_pkg.sv -----
// Shared constants and controller/datapath command and status types for the sorted
// character table search core. No dependencies.
`default_nettype none

package scbs_pkg;

    localparam int DEPTH_DEF = 256;
    localparam int DATA_W    = 8;
    localparam int FUNC_W    = 2;
    localparam int POS_W     = 8;

    localparam logic [DATA_W-1:0] SPACE_CODE = 8'h20;

    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic ld_start;
        logic ld_read;
        logic ld_shift;
        logic ld_place;
        logic set_ovf;
        logic clear;
        logic sr_start;
        logic sr_read;
        logic sr_hit;
        logic sr_miss;
        logic sr_go_up;
        logic sr_go_down;
        logic out_load;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic in_space;
        logic full;
        logic pos_zero;
        logic greater;
        logic sr_empty;
        logic sr_eq;
        logic sr_lt;
    } t_status;

endpackage

`default_nettype wire

// ----- sv/scbs_if.sv -----
// Handshake channel interfaces for the sorted character table search core.
// Depends on scbs_pkg for field widths.
`default_nettype none

interface scbs_in_if;
    logic                               valid;
    logic                               ready;
    logic [scbs_pkg::FUNC_W-1:0]        func;
    logic signed [scbs_pkg::DATA_W-1:0] char_value;

    modport source (output valid, output func, output char_value, input ready);
    modport sink   (input valid, input func, input char_value, output ready);
endinterface

interface scbs_out_if;
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [scbs_pkg::POS_W-1:0] position;
    logic                       overflowed;

    modport source (output valid, output found, output position, output overflowed,
                    input ready);
    modport sink   (input valid, input found, input position, input overflowed,
                    output ready);
endinterface

`default_nettype wire

// ----- sv/scbs_ram.sv -----
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module scbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/scbs_datapath.sv -----
// Datapath: table RAM, entry count, insertion pointer, search bounds,
// overflow flag and output word register. Depends on scbs_pkg, scbs_ram.
`default_nettype none

module scbs_datapath #(
    parameter int DEPTH = scbs_pkg::DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic signed [scbs_pkg::DATA_W-1:0] i_char,
    input  wire scbs_pkg::t_cmd                     i_cmd,
    output scbs_pkg::t_status                       o_status,
    output logic                                    o_found,
    output logic             [scbs_pkg::POS_W-1:0]  o_position,
    output logic                                    o_overflowed
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic        [CW-1:0]               r_count;
    logic        [CW-1:0]               r_pos;
    logic        [CW-1:0]               r_lo;
    logic        [CW-1:0]               r_hp1;
    logic                               r_ovf;
    logic signed [scbs_pkg::DATA_W-1:0] r_char;
    logic                               r_hit;
    logic        [AW-1:0]               r_where;

    logic        [CW-1:0]               w_span;
    logic        [CW-1:0]               w_mid;
    logic        [scbs_pkg::DATA_W-1:0] w_rdata;
    logic signed [scbs_pkg::DATA_W-1:0] w_rval;
    logic        [AW-1:0]               w_raddr;
    logic                               w_we;

    // Midpoint of the inclusive range lo .. hp1-1, rounded down
    assign w_span = r_hp1 - r_lo - CW'(1);
    assign w_mid  = r_lo + (w_span >> 1);

    assign w_rval  = $signed(w_rdata);
    assign w_raddr = i_cmd.sr_read ? AW'(w_mid) : AW'(r_pos - CW'(1));
    assign w_we    = i_cmd.ld_shift | i_cmd.ld_place;

    scbs_ram #(
        .WIDTH (scbs_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(r_pos)),
        .i_wdata (i_cmd.ld_place ? r_char : w_rdata),
        .i_re    (i_cmd.ld_read | i_cmd.sr_read),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Status back to the controller
    always_comb begin
        o_status.in_space = (i_char == scbs_pkg::SPACE_CODE);
        o_status.full     = (r_count == CW'(DEPTH));
        o_status.pos_zero = (r_pos == '0);
        o_status.greater  = (w_rval > r_char);
        o_status.sr_empty = (r_lo >= r_hp1);
        o_status.sr_eq    = (w_rval == r_char);
        o_status.sr_lt    = (w_rval < r_char);
    end

    // Count and overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else begin
                if (i_cmd.ld_place) begin
                    r_count <= r_count + CW'(1);
                end
                if (i_cmd.set_ovf) begin
                    r_ovf <= 1'b1;
                end
            end
        end
    end

    // Insertion pointer, search bounds and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_start || i_cmd.sr_start) begin
            r_char <= i_char;
        end
        if (i_cmd.ld_start) begin
            r_pos <= r_count;
        end else if (i_cmd.ld_shift) begin
            r_pos <= r_pos - CW'(1);
        end
        if (i_cmd.sr_start) begin
            r_lo  <= '0;
            r_hp1 <= r_count;
        end else if (i_cmd.sr_go_up) begin
            r_lo <= w_mid + CW'(1);
        end else if (i_cmd.sr_go_down) begin
            r_hp1 <= w_mid;
        end
        if (i_cmd.sr_hit) begin
            r_hit   <= 1'b1;
            r_where <= AW'(w_mid);
        end else if (i_cmd.sr_miss) begin
            r_hit   <= 1'b0;
            r_where <= '0;
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_found      <= r_hit;
            o_position   <= r_hit ? scbs_pkg::POS_W'(r_where) : '0;
            o_overflowed <= r_ovf;
        end
    end

endmodule

`default_nettype wire

// ----- sv/scbs_ctrl.sv -----
// Controller: sequences insertion shifts and binary search probes and owns
// the input ready and output valid. Depends on scbs_pkg and the macro header.
`default_nettype none
`include "sorted_char_table_binary_search_core_macros.svh"

module scbs_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic [scbs_pkg::FUNC_W-1:0]   i_func,
    output logic                               o_in_ready,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    input  wire scbs_pkg::t_status             i_status,
    output scbs_pkg::t_cmd                     o_cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LD_RD  = 3'd1;
    localparam logic [2:0] ST_LD_CMP = 3'd2;
    localparam logic [2:0] ST_SR_RD  = 3'd3;
    localparam logic [2:0] ST_SR_CMP = 3'd4;
    localparam logic [2:0] ST_SR_OUT = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_out_free;

    // Accept a word only when idle and out of reset
    assign o_in_ready  = (r_state == ST_IDLE) && i_rst_n;
    assign o_out_valid = r_out_valid;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_func)
                        scbs_pkg::FUNC_LOAD: begin
                            if (!i_status.in_space) begin
                                if (i_status.full) begin
                                    o_cmd.set_ovf = 1'b1;
                                end else begin
                                    o_cmd.ld_start = 1'b1;
                                    n_state        = ST_LD_RD;
                                end
                            end
                        end
                        scbs_pkg::FUNC_SEARCH: begin
                            o_cmd.sr_start = 1'b1;
                            n_state        = ST_SR_RD;
                        end
                        scbs_pkg::FUNC_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LD_RD: begin
                if (i_status.pos_zero) begin
                    o_cmd.ld_place = 1'b1;
                    n_state        = ST_IDLE;
                end else begin
                    o_cmd.ld_read = 1'b1;
                    n_state       = ST_LD_CMP;
                end
            end
            ST_LD_CMP: begin
                if (i_status.greater) begin
                    o_cmd.ld_shift = 1'b1;
                    n_state        = ST_LD_RD;
                end else begin
                    o_cmd.ld_place = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_SR_RD: begin
                if (i_status.sr_empty) begin
                    o_cmd.sr_miss = 1'b1;
                    n_state       = ST_SR_OUT;
                end else begin
                    o_cmd.sr_read = 1'b1;
                    n_state       = ST_SR_CMP;
                end
            end
            ST_SR_CMP: begin
                if (i_status.sr_eq) begin
                    o_cmd.sr_hit = 1'b1;
                    n_state      = ST_SR_OUT;
                end else begin
                    if (i_status.sr_lt) begin
                        o_cmd.sr_go_up = 1'b1;
                    end else begin
                        o_cmd.sr_go_down = 1'b1;
                    end
                    n_state = ST_SR_RD;
                end
            end
            ST_SR_OUT: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold output valid until the word is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `SCBS_ASSERT_NOW(a_ld_cmp_after_rd, r_state == ST_LD_CMP, $past(r_state) == ST_LD_RD, "load compare without a read")
    `SCBS_ASSERT_NOW(a_sr_cmp_after_rd, r_state == ST_SR_CMP, $past(r_state) == ST_SR_RD, "search compare without a read")
    `SCBS_ASSERT_NEXT(a_out_load_valid, r_state == ST_SR_OUT && w_out_free, r_out_valid && r_state == ST_IDLE, "result word not presented")
    `SCBS_ASSERT_NOW(a_one_ram_op, o_cmd.ld_read || o_cmd.sr_read, !o_cmd.ld_shift && !o_cmd.ld_place, "read issued with a write")

endmodule

`default_nettype wire

// ----- sv/sorted_char_table_binary_search_core.sv -----
// Sorted character table with binary search.
// Input channel i_in carries one word: func (0 load, 1 search, 2 clear, 3 ignored)
// and a signed char_value. Output channel o_out carries found, position and the
// sticky overflowed flag; only a search produces an output word.
// A load drops a space character, sets overflowed when the table is full, and
// otherwise inserts the character after any equal entries by shifting larger
// entries up one place. Each shifted entry takes a RAM read, then a compare
// and write. A search is accepted, then probes the midpoint of the remaining
// range, each probe a read on the RAM read port then a compare, then finishes
// and loads the output word; the word appears as i_in.ready returns. Clear, a
// dropped load and code 3 are done without leaving idle. One item is in work at
// a time.
// The output word sits in a register; a stalled receiver does not block the next
// load or clear, and a following search waits for the register to empty.
// Reset empties the table and clears overflowed and the output valid at once;
// the table RAM holds no reset value and needs no clearing pass.
// Depends on scbs_pkg, the channel interfaces, scbs_ctrl and scbs_datapath.
`default_nettype none

module sorted_char_table_binary_search_core #(
    parameter int DEPTH = scbs_pkg::DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    scbs_in_if.sink    i_in,
    scbs_out_if.source o_out
);

    scbs_pkg::t_cmd    w_cmd;
    scbs_pkg::t_status w_status;

    scbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_func      (i_in.func),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    scbs_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char       (i_in.char_value),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_found      (o_out.found),
        .o_position   (o_out.position),
        .o_overflowed (o_out.overflowed)
    );

endmodule

`default_nettype wire
